// ===== hw/rtl/lobm_pkg.sv =====
// Shared types and constants for the limit order book matcher
package lobm_pkg;
    localparam int BOOK_DEPTH = 32;
    localparam int PRICE_BITS = 16;
    localparam int QTY_BITS   = 16;
    localparam int ID_BITS    = 10;
    localparam int IDX_BITS   = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(BOOK_DEPTH + 1);
    localparam int PAY_BITS   = 32;
    localparam int NTR_BITS   = $clog2(2 * BOOK_DEPTH);

    localparam logic [1:0] OP_BUY   = 2'd0;
    localparam logic [1:0] OP_SELL  = 2'd1;
    localparam logic [1:0] OP_MATCH = 2'd2;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_FULL   = 2'd1;
    localparam logic [1:0] KIND_TRADE  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef struct packed {
        logic insert_bid;
        logic insert_ask;
        logic scan_start;
        logic scan_step;
        logic trade;
        logic rm_bid_start;
        logic rm_ask_start;
        logic rm_step;
        logic pay_load;
    } cmd_t;

    typedef struct packed {
        logic bid_full;
        logic ask_full;
        logic books_nonempty;
        logic scan_done;
        logic crossed;
        logic bid_filled;
        logic ask_filled;
        logic rm_done;
    } stat_t;
endpackage

// ===== hw/rtl/limit_order_book_matcher_unit.sv =====
// Price-time priority limit order book matcher, top level
// Buy/sell transaction: result registered in the cycle after acceptance; one transaction
// per cycle while the result is not stalled. Match transaction: each trade follows a
// sequential scan of both books, then evaluation, payment and removal of filled orders.
// A stalled result holds the sequencer before the next trade and at the result register.
// Reset: books empty, last price 0; book entries are not cleared.
module limit_order_book_matcher_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           op,
    input  logic [lobm_pkg::ID_BITS-1:0]         user_id,
    input  logic [lobm_pkg::QTY_BITS-1:0]        quantity,
    input  logic [lobm_pkg::PRICE_BITS-1:0]      limit_price,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           kind,
    output logic [lobm_pkg::ID_BITS-1:0]         buyer_id,
    output logic [lobm_pkg::ID_BITS-1:0]         seller_id,
    output logic [lobm_pkg::QTY_BITS-1:0]        trade_quantity,
    output logic [lobm_pkg::PRICE_BITS-1:0]      trade_price,
    output logic [31:0]                          payment,
    output logic [lobm_pkg::PRICE_BITS-1:0]      current_price,
    output logic                                 last
);
    lobm_pkg::cmd_t  cmd;
    lobm_pkg::stat_t stat;
    logic            show_trade;
    logic [lobm_pkg::ID_BITS-1:0]    d_buyer, d_seller;
    logic [lobm_pkg::QTY_BITS-1:0]   d_tq;
    logic [lobm_pkg::PRICE_BITS-1:0] d_tp, d_cur;
    logic [31:0]                     d_pay;
    logic [lobm_pkg::PRICE_BITS-1:0] cur_reg;

    lobm_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .last       (last),
        .show_trade (show_trade),
        .cmd        (cmd),
        .stat       (stat)
    );

    lobm_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .user_id        (user_id),
        .quantity       (quantity),
        .limit_price    (limit_price),
        .buyer_id       (d_buyer),
        .seller_id      (d_seller),
        .trade_quantity (d_tq),
        .trade_price    (d_tp),
        .payment        (d_pay),
        .current_price  (d_cur)
    );

    // current price snapshot, reloaded while the result register is free and held while it stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else if (!out_valid || !out_stall)
            cur_reg <= d_cur;
    end

    assign buyer_id       = show_trade ? d_buyer : '0;
    assign seller_id      = show_trade ? d_seller : '0;
    assign trade_quantity = show_trade ? d_tq : '0;
    assign trade_price    = show_trade ? d_tp : '0;
    assign payment        = show_trade ? d_pay : '0;
    assign current_price  = cur_reg;

    a_trade_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (show_trade == (kind == lobm_pkg::KIND_TRADE)))
        else $error("trade flag and kind disagree");
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == lobm_pkg::KIND_TRADE |-> !last)
        else $error("trade result marked last");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.trade || cmd.rm_step) |-> in_stall)
        else $error("input taken while matching");
endmodule

// ===== hw/rtl/lobm_datapath.sv =====
// Order book storage, best price scan, trade arithmetic and compaction
module lobm_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lobm_pkg::cmd_t                       cmd,
    output lobm_pkg::stat_t                      stat,
    input  logic [lobm_pkg::ID_BITS-1:0]         user_id,
    input  logic [lobm_pkg::QTY_BITS-1:0]        quantity,
    input  logic [lobm_pkg::PRICE_BITS-1:0]      limit_price,
    output logic [lobm_pkg::ID_BITS-1:0]         buyer_id,
    output logic [lobm_pkg::ID_BITS-1:0]         seller_id,
    output logic [lobm_pkg::QTY_BITS-1:0]        trade_quantity,
    output logic [lobm_pkg::PRICE_BITS-1:0]      trade_price,
    output logic [lobm_pkg::PAY_BITS-1:0]        payment,
    output logic [lobm_pkg::PRICE_BITS-1:0]      current_price
);
    localparam int PB = lobm_pkg::PRICE_BITS;
    localparam int QB = lobm_pkg::QTY_BITS;
    localparam int IB = lobm_pkg::ID_BITS;
    localparam int XB = lobm_pkg::IDX_BITS;
    localparam int CB = lobm_pkg::CNT_BITS;
    localparam int D  = lobm_pkg::BOOK_DEPTH;
    localparam int PAY_W = lobm_pkg::PAY_BITS;

    logic [PB-1:0] bid_p [D];
    logic [IB-1:0] bid_o [D];
    logic [QB-1:0] bid_q [D];
    logic [PB-1:0] ask_p [D];
    logic [IB-1:0] ask_o [D];
    logic [QB-1:0] ask_q [D];

    logic [CB-1:0] bid_cnt_reg, bid_cnt_next;
    logic [CB-1:0] ask_cnt_reg, ask_cnt_next;
    logic [PB-1:0] last_price_reg, last_price_next;
    logic [CB-1:0] scan_reg, scan_next;
    logic [XB-1:0] bi_reg, ai_reg;
    logic [PB-1:0] bp_reg, ap_reg;
    logic [QB-1:0] bq_reg, aq_reg;
    logic [IB-1:0] bo_reg, ao_reg;
    logic [PB-1:0] bpr_reg, apr_reg;
    logic [QB-1:0] bqr_reg, aqr_reg;
    logic [IB-1:0] bor_reg, aor_reg;
    logic [QB-1:0] tq_reg;
    logic [PB-1:0] tp_reg;
    logic [IB-1:0] buyer_reg, seller_reg;
    logic [PAY_W-1:0] pay_reg;
    logic [CB-1:0] rm_reg;
    logic          rm_bid_reg;
    logic          bfill_reg, afill_reg;
    logic [QB-1:0] tq_c;
    logic [XB-1:0] rm_i, rm_i1;
    logic [XB-1:0] sidx;
    logic [CB-1:0] rm_lim;
    logic          scan_go;

    assign sidx  = scan_reg[XB-1:0];
    assign rm_i  = rm_reg[XB-1:0];
    assign rm_i1 = XB'(rm_reg + CB'(1));
    assign tq_c  = (bq_reg < aq_reg) ? bq_reg : aq_reg;
    assign rm_lim = rm_bid_reg ? bid_cnt_reg : ask_cnt_reg;
    assign scan_go = cmd.scan_step && ((scan_reg < bid_cnt_reg) || (scan_reg < ask_cnt_reg));

    // book memories: one write port per book, scan reads registered
    always_ff @(posedge clk)
    begin
        if (cmd.insert_bid)
        begin
            bid_p[bid_cnt_reg[XB-1:0]] <= limit_price;
            bid_o[bid_cnt_reg[XB-1:0]] <= user_id;
            bid_q[bid_cnt_reg[XB-1:0]] <= quantity;
        end
        else if (cmd.trade)
        begin
            bid_q[bi_reg] <= bq_reg - tq_c;
        end
        else if (cmd.rm_step && rm_bid_reg)
        begin
            bid_p[rm_i] <= bid_p[rm_i1];
            bid_o[rm_i] <= bid_o[rm_i1];
            bid_q[rm_i] <= bid_q[rm_i1];
        end
        if (cmd.insert_ask)
        begin
            ask_p[ask_cnt_reg[XB-1:0]] <= limit_price;
            ask_o[ask_cnt_reg[XB-1:0]] <= user_id;
            ask_q[ask_cnt_reg[XB-1:0]] <= quantity;
        end
        else if (cmd.trade)
        begin
            ask_q[ai_reg] <= aq_reg - tq_c;
        end
        else if (cmd.rm_step && !rm_bid_reg)
        begin
            ask_p[rm_i] <= ask_p[rm_i1];
            ask_o[rm_i] <= ask_o[rm_i1];
            ask_q[rm_i] <= ask_q[rm_i1];
        end
        bpr_reg <= bid_p[sidx];
        bqr_reg <= bid_q[sidx];
        bor_reg <= bid_o[sidx];
        apr_reg <= ask_p[sidx];
        aqr_reg <= ask_q[sidx];
        aor_reg <= ask_o[sidx];
    end

    logic scan_rd_reg;
    logic [CB-1:0] scan_prev_reg;

    always_comb
    begin
        scan_next = scan_reg;
        if (cmd.scan_start)
            scan_next = '0;
        else if (scan_go)
            scan_next = scan_reg + CB'(1);
    end

    always_comb
    begin
        bid_cnt_next = bid_cnt_reg;
        ask_cnt_next = ask_cnt_reg;
        if (cmd.insert_bid)
            bid_cnt_next = bid_cnt_reg + CB'(1);
        if (cmd.insert_ask)
            ask_cnt_next = ask_cnt_reg + CB'(1);
        if (cmd.rm_step && (rm_reg + CB'(1) >= rm_lim))
        begin
            if (rm_bid_reg)
                bid_cnt_next = bid_cnt_reg - CB'(1);
            else
                ask_cnt_next = ask_cnt_reg - CB'(1);
        end
        last_price_next = cmd.trade ? bp_reg : last_price_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_cnt_reg    <= '0;
            ask_cnt_reg    <= '0;
            last_price_reg <= '0;
            scan_reg       <= '0;
            scan_rd_reg    <= 1'b0;
            rm_reg         <= '0;
            rm_bid_reg     <= 1'b0;
        end
        else
        begin
            bid_cnt_reg    <= bid_cnt_next;
            ask_cnt_reg    <= ask_cnt_next;
            last_price_reg <= last_price_next;
            scan_reg       <= scan_next;
            scan_rd_reg    <= scan_go;
            if (cmd.rm_bid_start)
            begin
                rm_reg     <= CB'(bi_reg);
                rm_bid_reg <= 1'b1;
            end
            else if (cmd.rm_ask_start)
            begin
                rm_reg     <= CB'(ai_reg);
                rm_bid_reg <= 1'b0;
            end
            else if (cmd.rm_step)
            begin
                rm_reg <= rm_reg + CB'(1);
            end
        end
    end

    // running best: entry read last cycle is compared here
    always_ff @(posedge clk)
    begin
        scan_prev_reg <= scan_reg;
        if (scan_rd_reg)
        begin
            if (scan_prev_reg < bid_cnt_reg &&
                (scan_prev_reg == '0 || bpr_reg > bp_reg))
            begin
                bp_reg <= bpr_reg;
                bq_reg <= bqr_reg;
                bo_reg <= bor_reg;
                bi_reg <= scan_prev_reg[XB-1:0];
            end
            if (scan_prev_reg < ask_cnt_reg &&
                (scan_prev_reg == '0 || apr_reg < ap_reg))
            begin
                ap_reg <= apr_reg;
                aq_reg <= aqr_reg;
                ao_reg <= aor_reg;
                ai_reg <= scan_prev_reg[XB-1:0];
            end
        end
        if (cmd.trade)
        begin
            tq_reg     <= tq_c;
            tp_reg     <= bp_reg;
            buyer_reg  <= bo_reg;
            seller_reg <= ao_reg;
            bfill_reg  <= (bq_reg == tq_c);
            afill_reg  <= (aq_reg == tq_c);
        end
        if (cmd.pay_load)
            pay_reg <= PAY_W'(tq_reg) * PAY_W'(tp_reg);
    end

    assign stat.bid_full       = (bid_cnt_reg == CB'(D));
    assign stat.ask_full       = (ask_cnt_reg == CB'(D));
    assign stat.books_nonempty = (bid_cnt_reg != '0) && (ask_cnt_reg != '0);
    assign stat.scan_done      = !scan_rd_reg && (scan_reg >= bid_cnt_reg)
                                 && (scan_reg >= ask_cnt_reg);
    assign stat.crossed        = (bp_reg >= ap_reg);
    assign stat.bid_filled     = bfill_reg;
    assign stat.ask_filled     = afill_reg;
    assign stat.rm_done        = (rm_reg + CB'(1) >= rm_lim);

    assign buyer_id       = buyer_reg;
    assign seller_id      = seller_reg;
    assign trade_quantity = tq_reg;
    assign trade_price    = tp_reg;
    assign payment        = pay_reg;
    assign current_price  = last_price_reg;
endmodule

// ===== hw/rtl/lobm_ctrl.sv =====
// Sequencer for insert, scan, trade and removal steps and the result handshake
module lobm_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              op,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              kind,
    output logic                    last,
    output logic                    show_trade,
    output lobm_pkg::cmd_t          cmd,
    input  lobm_pkg::stat_t         stat
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_PAY   = 3'd3;
    localparam logic [2:0] S_RMB   = 3'd4;
    localparam logic [2:0] S_RMA   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic [1:0] kind_reg, kind_next;
    logic       last_reg, last_next;
    logic       trd_reg, trd_next;
    logic       rmb_pend_reg, rmb_pend_next;
    logic       out_free;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;

    always_comb
    begin
        state_next    = state_reg;
        ov_next       = ov_reg && out_stall;
        kind_next     = kind_reg;
        last_next     = last_reg;
        trd_next      = trd_reg;
        rmb_pend_next = rmb_pend_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    case (op)
                        lobm_pkg::OP_BUY, lobm_pkg::OP_SELL:
                        begin
                            ov_next   = 1'b1;
                            last_next = 1'b1;
                            trd_next  = 1'b0;
                            if ((op == lobm_pkg::OP_BUY) ? stat.bid_full : stat.ask_full)
                                kind_next = lobm_pkg::KIND_FULL;
                            else
                            begin
                                kind_next      = lobm_pkg::KIND_ACCEPT;
                                cmd.insert_bid = (op == lobm_pkg::OP_BUY);
                                cmd.insert_ask = (op == lobm_pkg::OP_SELL);
                            end
                        end
                        lobm_pkg::OP_MATCH:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!stat.books_nonempty)
                begin
                    state_next = S_OUT;
                    kind_next  = lobm_pkg::KIND_DONE;
                end
                else if (stat.scan_done)
                    state_next = S_EVAL;
                else
                    cmd.scan_step = 1'b1;
            end
            S_EVAL:
            begin
                // trade fields feed the result port, so wait until it is free
                if (out_free)
                begin
                    if (stat.crossed)
                    begin
                        cmd.trade  = 1'b1;
                        state_next = S_PAY;
                    end
                    else
                    begin
                        kind_next  = lobm_pkg::KIND_DONE;
                        state_next = S_OUT;
                    end
                end
            end
            S_PAY:
            begin
                cmd.pay_load  = 1'b1;
                kind_next     = lobm_pkg::KIND_TRADE;
                rmb_pend_next = stat.bid_filled;
                if (stat.bid_filled)
                begin
                    cmd.rm_bid_start = 1'b1;
                    state_next       = S_RMB;
                end
                else if (stat.ask_filled)
                begin
                    cmd.rm_ask_start = 1'b1;
                    state_next       = S_RMA;
                end
                else
                    state_next = S_OUT;
            end
            S_RMB:
            begin
                cmd.rm_step = 1'b1;
                if (stat.rm_done)
                begin
                    if (stat.ask_filled)
                    begin
                        state_next = S_RMA;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_RMA:
            begin
                if (rmb_pend_reg)
                begin
                    cmd.rm_ask_start = 1'b1;
                    rmb_pend_next    = 1'b0;
                end
                else
                begin
                    cmd.rm_step = 1'b1;
                    if (stat.rm_done)
                        state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    trd_next = (kind_reg == lobm_pkg::KIND_TRADE);
                    last_next = (kind_reg == lobm_pkg::KIND_DONE);
                    if (kind_reg == lobm_pkg::KIND_DONE)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ov_reg       <= 1'b0;
            kind_reg     <= lobm_pkg::KIND_ACCEPT;
            last_reg     <= 1'b0;
            trd_reg      <= 1'b0;
            rmb_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ov_reg       <= ov_next;
            kind_reg     <= kind_next;
            last_reg     <= last_next;
            trd_reg      <= trd_next;
            rmb_pend_reg <= rmb_pend_next;
        end
    end

    // output kind is captured at presentation
    logic [1:0] okind_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            okind_reg <= lobm_pkg::KIND_ACCEPT;
        else if (ov_next && out_free)
            okind_reg <= kind_next;
    end

    assign out_valid  = ov_reg;
    assign kind       = okind_reg;
    assign last       = last_reg;
    assign show_trade = trd_reg;
endmodule

// ===== tb/sv/limit_order_book_matcher_unit_tb.sv =====
// Testbench for the limit order book matcher: directed and random orders and matches checked against a predictor
`timescale 1ns / 1ps

module limit_order_book_matcher_unit_tb;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NUM_ITEMS = 310;
    localparam int IDLE_LIMIT = 40000;
    localparam int IB = lobm_pkg::ID_BITS;
    localparam int QB = lobm_pkg::QTY_BITS;
    localparam int PB = lobm_pkg::PRICE_BITS;
    localparam int D  = lobm_pkg::BOOK_DEPTH;

    typedef struct {
        logic [1:0]    op;
        logic [IB-1:0] uid;
        logic [QB-1:0] qty;
        logic [PB-1:0] prc;
        bit            hold;
        int            phase;
    } order_t;

    typedef struct {
        logic [1:0]    kind;
        logic [IB-1:0] buyer;
        logic [IB-1:0] seller;
        logic [QB-1:0] qty;
        logic [PB-1:0] prc;
        logic [31:0]   pay;
        logic [PB-1:0] cur;
        logic          last;
    } report_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [1:0]    op;
    logic [IB-1:0] user_id;
    logic [QB-1:0] quantity;
    logic [PB-1:0] limit_price;
    logic          out_valid;
    logic          out_stall;
    logic [1:0]    kind;
    logic [IB-1:0] buyer_id;
    logic [IB-1:0] seller_id;
    logic [QB-1:0] trade_quantity;
    logic [PB-1:0] trade_price;
    logic [31:0]   payment;
    logic [PB-1:0] current_price;
    logic          last;

    limit_order_book_matcher_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .user_id(user_id), .quantity(quantity), .limit_price(limit_price),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .buyer_id(buyer_id), .seller_id(seller_id),
        .trade_quantity(trade_quantity), .trade_price(trade_price),
        .payment(payment), .current_price(current_price), .last(last)
    );

    order_t  pending_orders[$];
    report_t expected_reports[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    int      cur_phase = 0;
    int      n_items = 0;

    // book model
    logic [PB-1:0] bid_px[D];
    logic [IB-1:0] bid_who[D];
    logic [QB-1:0] bid_qty[D];
    int            n_bids = 0;
    logic [PB-1:0] ask_px[D];
    logic [IB-1:0] ask_who[D];
    logic [QB-1:0] ask_qty[D];
    int            n_asks = 0;
    logic [PB-1:0] last_px = '0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void add_report(logic [1:0] k, logic [IB-1:0] b,
                                       logic [IB-1:0] s, logic [QB-1:0] q,
                                       logic [PB-1:0] p, logic l);
        report_t r;
        r.kind = k;
        r.buyer = b;
        r.seller = s;
        r.qty = q;
        r.prc = p;
        r.pay = 32'(q) * 32'(p);
        r.cur = last_px;
        r.last = l;
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    function automatic void apply_order(order_t it);
        int bi, ai, ntr;
        logic [QB-1:0] tq;
        logic [PB-1:0] tp;
        logic [IB-1:0] b, s;
        if (it.op == lobm_pkg::OP_BUY)
        begin
            if (n_bids < D)
            begin
                bid_px[n_bids] = it.prc;
                bid_who[n_bids] = it.uid;
                bid_qty[n_bids] = it.qty;
                n_bids++;
                add_report(lobm_pkg::KIND_ACCEPT, '0, '0, '0, '0, 1'b1);
            end
            else
                add_report(lobm_pkg::KIND_FULL, '0, '0, '0, '0, 1'b1);
        end
        else if (it.op == lobm_pkg::OP_SELL)
        begin
            if (n_asks < D)
            begin
                ask_px[n_asks] = it.prc;
                ask_who[n_asks] = it.uid;
                ask_qty[n_asks] = it.qty;
                n_asks++;
                add_report(lobm_pkg::KIND_ACCEPT, '0, '0, '0, '0, 1'b1);
            end
            else
                add_report(lobm_pkg::KIND_FULL, '0, '0, '0, '0, 1'b1);
        end
        else if (it.op == lobm_pkg::OP_MATCH)
        begin
            ntr = 0;
            while (n_bids > 0 && n_asks > 0 && ntr < 2 * D - 1)
            begin
                bi = 0;
                ai = 0;
                for (int i = 1; i < n_bids; i++)
                    if (bid_px[i] > bid_px[bi]) bi = i;
                for (int i = 1; i < n_asks; i++)
                    if (ask_px[i] < ask_px[ai]) ai = i;
                if (bid_px[bi] < ask_px[ai])
                    break;
                tp = bid_px[bi];
                tq = (bid_qty[bi] < ask_qty[ai]) ? bid_qty[bi] : ask_qty[ai];
                b = bid_who[bi];
                s = ask_who[ai];
                bid_qty[bi] -= tq;
                ask_qty[ai] -= tq;
                if (bid_qty[bi] == 0)
                begin
                    for (int i = bi; i + 1 < n_bids; i++)
                    begin
                        bid_px[i] = bid_px[i+1];
                        bid_who[i] = bid_who[i+1];
                        bid_qty[i] = bid_qty[i+1];
                    end
                    n_bids--;
                end
                if (ask_qty[ai] == 0)
                begin
                    for (int i = ai; i + 1 < n_asks; i++)
                    begin
                        ask_px[i] = ask_px[i+1];
                        ask_who[i] = ask_who[i+1];
                        ask_qty[i] = ask_qty[i+1];
                    end
                    n_asks--;
                end
                last_px = tp;
                add_report(lobm_pkg::KIND_TRADE, b, s, tq, tp, 1'b0);
                ntr++;
            end
            add_report(lobm_pkg::KIND_DONE, '0, '0, '0, '0, 1'b1);
        end
    endfunction

    function automatic int idle_pct(int ph, bit rx);
        case (ph)
            1: return rx ? 0 : 64;
            2: return rx ? 64 : 0;
            3: return 28;
            default: return 0;
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        order_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                it.op = op;
                it.uid = user_id;
                it.qty = quantity;
                it.prc = limit_price;
                apply_order(it);
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_orders.size() > 0
                    && !(pending_orders[0].hold && expected_reports.size() > 0)
                    && $urandom_range(99) >= idle_pct(pending_orders[0].phase, 0))
                begin
                    it = pending_orders.pop_front();
                    cur_phase <= it.phase;
                    op <= it.op;
                    user_id <= it.uid;
                    quantity <= it.qty;
                    limit_price <= it.prc;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        report_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d", kind);
                end
                else
                begin
                    e = expected_reports.pop_front();
                    if (kind !== e.kind || buyer_id !== e.buyer || seller_id !== e.seller
                        || trade_quantity !== e.qty || trade_price !== e.prc
                        || payment !== e.pay || current_price !== e.cur || last !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp k=%0d b=%0d s=%0d q=%0d p=%0d pay=%0d ",
                                      "cur=%0d l=%0d got k=%0d b=%0d s=%0d q=%0d p=%0d ",
                                      "pay=%0d cur=%0d l=%0d"},
                                     e.kind, e.buyer, e.seller, e.qty, e.prc, e.pay, e.cur,
                                     e.last, kind, buyer_id, seller_id, trade_quantity,
                                     trade_price, payment, current_price, last);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct(cur_phase, 1));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic add_order(logic [1:0] o, int u, int q, int p);
        order_t it;
        it.op = o;
        it.uid = IB'(u);
        it.qty = QB'(q);
        it.prc = PB'(p);
        it.phase = (n_items * 4 / NUM_ITEMS > 3) ? 3 : n_items * 4 / NUM_ITEMS;
        it.hold = (pending_orders.size() > 0 && pending_orders[$].phase != it.phase)
                  || ($urandom_range(99) < 2);
        pending_orders.insert(pending_orders.size(), it);
        if (o != OP_UNUSED)
            n_items++;
    endtask

    function automatic int rand_qty();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 0;
        if (r < 20) return $urandom_range(65535);
        return $urandom_range(1, 100);
    endfunction

    initial
    begin
        int base, sprd, cnt;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        op = lobm_pkg::OP_BUY;
        user_id = '0;
        quantity = '0;
        limit_price = '0;

        // directed
        add_order(lobm_pkg::OP_MATCH, 0, 0, 0);
        add_order(lobm_pkg::OP_BUY, 0, 100, 1);
        add_order(lobm_pkg::OP_MATCH, 0, 0, 0);
        add_order(lobm_pkg::OP_SELL, 1023, 100, 1);
        add_order(lobm_pkg::OP_MATCH, 0, 0, 0);
        add_order(lobm_pkg::OP_BUY, 1023, 0, 65535);
        add_order(lobm_pkg::OP_SELL, 0, 65535, 0);
        add_order(lobm_pkg::OP_MATCH, 0, 0, 0);
        add_order(lobm_pkg::OP_BUY, 512, 65535, 65535);
        add_order(lobm_pkg::OP_MATCH, 0, 0, 0);
        add_order(lobm_pkg::OP_SELL, 1, 10, 50);
        add_order(lobm_pkg::OP_SELL, 2, 10, 50);
        add_order(lobm_pkg::OP_BUY, 3, 15, 60);
        add_order(lobm_pkg::OP_BUY, 4, 5, 60);
        add_order(OP_UNUSED, 1023, 65535, 65535);
        add_order(lobm_pkg::OP_MATCH, 1023, 65535, 65535);
        add_order(lobm_pkg::OP_BUY, 5, 7, 49);
        add_order(lobm_pkg::OP_SELL, 6, 3, 30);
        add_order(lobm_pkg::OP_MATCH, 0, 0, 0);
        add_order(lobm_pkg::OP_BUY, 341, 21845, 43690);
        add_order(lobm_pkg::OP_SELL, 682, 43690, 21845);
        add_order(lobm_pkg::OP_MATCH, 0, 0, 0);

        // random episodes, first one fills both books
        cnt = 0;
        while (n_items < NUM_ITEMS)
        begin
            base = $urandom_range(25, 65510);
            sprd = ($urandom_range(3) == 0) ? 20 : 4;
            if (cnt == 0 || $urandom_range(99) < 8)
            begin
                for (int i = 0; i < D + 2; i++)
                    add_order(lobm_pkg::OP_BUY, $urandom_range(1023), rand_qty(),
                              $urandom_range(base, base + sprd));
                if ($urandom_range(1) == 1 || cnt == 0)
                    for (int i = 0; i < D + 1; i++)
                        add_order(lobm_pkg::OP_SELL, $urandom_range(1023), rand_qty(),
                                  $urandom_range(base - sprd, base));
            end
            else if ($urandom_range(99) < 10)
            begin
                for (int i = 0; i < 3; i++)
                    add_order($urandom_range(99) < 50 ? OP_UNUSED : 2'($urandom_range(2)),
                              $urandom_range(1023), $urandom_range(65535),
                              $urandom_range(65535));
            end
            else
            begin
                for (int i = $urandom_range(2, 8); i > 0; i--)
                    add_order($urandom_range(1) ? lobm_pkg::OP_BUY : lobm_pkg::OP_SELL,
                              $urandom_range(1023), rand_qty(),
                              $urandom_range(base - sprd, base + sprd));
            end
            if ($urandom_range(99) < 90)
                add_order(lobm_pkg::OP_MATCH, $urandom_range(1023), $urandom_range(65535),
                          $urandom_range(65535));
            cnt++;
        end
        add_order(lobm_pkg::OP_MATCH, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_orders.size() == 0 && !in_valid && expected_reports.size() == 0);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_datapath.sv
hw/rtl/lobm_ctrl.sv
hw/rtl/limit_order_book_matcher_unit.sv
tb/sv/limit_order_book_matcher_unit_tb.sv
